// ===== rtl/core/qph_pkg.sv =====
// Shared constants for the quadratic-probe hash table.
// Used by the top level and the checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package qph_pkg;

  localparam int TABLE_DEPTH = 16384;
  localparam int KEY_BITS    = 32;
  localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
  localparam int SIZE_BITS   = ADDR_BITS + 1;
  localparam int CNT_BITS    = ADDR_BITS + 1;
  localparam int DIV_BITS    = $clog2(KEY_BITS);

  // Result word: success, probe count, slot index, padded to whole bytes.
  localparam int RES_BITS = 1 + CNT_BITS + ADDR_BITS;
  localparam int OUT_BITS = ((RES_BITS + 7) / 8) * 8;
  localparam int PAD_BITS = OUT_BITS - RES_BITS;

  localparam logic [SIZE_BITS-1:0] SIZE_MIN   = SIZE_BITS'(2);
  localparam logic [SIZE_BITS-1:0] SIZE_MAX   = SIZE_BITS'(TABLE_DEPTH);
  localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(2);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/core/quadratic_probe_hash_table_top.sv =====
// Each item runs through the states in order: bit-serial key mod size (ST_DIV), the first read
// (ST_READ), one probe per cycle in ST_CHECK (up to size+1 probes), and ST_DONE, which loads
// the output register once it is free. Items are handled one at a time; the next item is taken
// once the current one has left for the output register. The bit-serial remainder unit and the
// single RAM port set this pace. Reset is synchronous; after it the block runs a clearing pass
// over the slot memory and accepts no item until it is done.
`timescale 1ns / 1ps
`default_nettype none

module quadratic_probe_hash_table_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Input stream. tdata: key [31:0]. tuser: operation [0] (0 insert, 1 search).
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [qph_pkg::KEY_BITS-1:0]  s_axis_tdata,
  input  wire logic [0:0]                    s_axis_tuser,
  // Result stream. tdata: success [0], probe_count [15:1], slot_index [29:16], zeros [31:30].
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [qph_pkg::OUT_BITS-1:0]       m_axis_tdata,
  // Table size register write channel.
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [qph_pkg::SIZE_BITS-1:0] cfg_data
);

  localparam int AW = qph_pkg::ADDR_BITS;
  localparam int SW = qph_pkg::SIZE_BITS;
  localparam int CW = qph_pkg::CNT_BITS;
  localparam int KW = qph_pkg::KEY_BITS;
  localparam int DW = qph_pkg::DIV_BITS;

  // Controller states.
  localparam logic [2:0] ST_CLEAR = 3'd0;  // zeroing the slot memory after reset
  localparam logic [2:0] ST_IDLE  = 3'd1;  // waiting for an input transfer
  localparam logic [2:0] ST_DIV   = 3'd2;  // bit-serial key mod size
  localparam logic [2:0] ST_READ  = 3'd3;  // first probe read issued
  localparam logic [2:0] ST_CHECK = 3'd4;  // slot data on the RAM output, one probe per cycle
  localparam logic [2:0] ST_DONE  = 3'd5;  // result waits for the output register

  logic [2:0]    state;
  logic [AW-1:0] clr_addr;

  // The table size register; writes are taken at any time.
  logic [SW-1:0] table_size;
  logic [SW-1:0] eff_size;

  // Per-item working registers.
  logic          op;
  logic [KW-1:0] key;
  logic [KW-1:0] kshift;
  logic [DW-1:0] div_cnt;
  logic [AW-1:0] rem;
  logic [SW-1:0] size;
  logic [AW-1:0] slot;
  logic [AW-1:0] inc;
  logic [CW-1:0] cnt;
  logic          ok;

  // Output register.
  logic          out_success;
  logic [CW-1:0] out_count;
  logic [AW-1:0] out_slot;

  logic          in_xfer;
  logic          out_free;

  // RAM port.
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [KW-1:0] ram_wdata;
  logic [KW-1:0] ram_rdata;

  // Datapath nets.
  logic [SW-1:0] div_trial;
  logic [AW-1:0] rem_next;
  logic [SW-1:0] slot_sum;
  logic [AW-1:0] slot_next;
  logic [SW-1:0] inc_sum;
  logic [AW-1:0] inc_next;
  logic          slot_empty;
  logic          slot_match;
  logic          hit;
  logic          hit_ok;
  logic          last_probe;
  logic          finish;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= qph_pkg::SIZE_RESET;
    end else if (cfg_valid) begin
      table_size <= cfg_data;
    end
  end

  // The size in use is the register clamped into the range the memory supports.
  always_comb begin
    if (table_size < qph_pkg::SIZE_MIN) begin
      eff_size = qph_pkg::SIZE_MIN;
    end else if (table_size > qph_pkg::SIZE_MAX) begin
      eff_size = qph_pkg::SIZE_MAX;
    end else begin
      eff_size = table_size;
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // One restoring step of key mod size per cycle, most significant key bit first.
  // The partial remainder stays below size, so it fits the slot index width.
  always_comb begin
    div_trial = {rem, kshift[KW-1]};
    if (div_trial >= size) begin
      div_trial = div_trial - size;
    end
    rem_next = div_trial[AW-1:0];
  end

  // Probe j+1 sits (2j+1) past probe j, so the slot and the odd step are both kept
  // reduced mod size and advanced with one add and conditional subtract each.
  always_comb begin
    slot_sum = {1'b0, slot} + {1'b0, inc};
    if (slot_sum >= size) begin
      slot_sum = slot_sum - size;
    end
    slot_next = slot_sum[AW-1:0];
    inc_sum = {1'b0, inc} + SW'(2);
    if (inc_sum >= size) begin
      inc_sum = inc_sum - size;
    end
    inc_next = inc_sum[AW-1:0];
  end

  // Probe decision on the slot just read. An empty slot never counts as a match.
  assign slot_empty = (ram_rdata == '0);
  assign slot_match = (ram_rdata == key);
  assign last_probe = (cnt > size);
  assign hit        = slot_empty || (op == qph_pkg::OP_SEARCH && slot_match);
  assign hit_ok     = (op == qph_pkg::OP_INSERT) ? slot_empty : (slot_match && !slot_empty);
  assign finish     = hit || last_probe;

  // A single port serves clearing, probe reads and the insert write-back. The write
  // happens only on the final probe, so it never meets a read of the same item.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = slot;
    ram_wdata = key;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr;
        ram_wdata = '0;
      end
      ST_CHECK: begin
        if (op == qph_pkg::OP_INSERT && slot_empty) begin
          ram_we = 1'b1;
        end else if (!finish) begin
          ram_addr = slot_next;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  qph_ram #(
    .WIDTH (KW),
    .DEPTH (qph_pkg::TABLE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Controller.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(qph_pkg::TABLE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_xfer) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_cnt == DW'(KW - 1)) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (finish) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Per-item datapath; payload registers need no reset.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          op      <= s_axis_tuser[0];
          key     <= s_axis_tdata;
          kshift  <= s_axis_tdata;
          size    <= eff_size;
          rem     <= '0;
          div_cnt <= '0;
        end
      end
      ST_DIV: begin
        rem     <= rem_next;
        kshift  <= {kshift[KW-2:0], 1'b0};
        div_cnt <= div_cnt + DW'(1);
        slot    <= rem_next;
        inc     <= AW'(1);
        cnt     <= CW'(1);
      end
      ST_CHECK: begin
        if (finish) begin
          ok <= hit_ok;
        end else begin
          slot <= slot_next;
          inc  <= inc_next;
          cnt  <= cnt + CW'(1);
        end
      end
      default: begin
        ok <= ok;
      end
    endcase
  end

  // Output register: loaded from a finished item while it is empty or the previous result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_success <= ok;
      out_count   <= cnt;
      out_slot    <= slot;
    end
  end

  assign m_axis_tdata = {{qph_pkg::PAD_BITS{1'b0}}, out_slot, out_count, out_success};

endmodule

`default_nettype wire

// ===== rtl/core/qph_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// Self-contained; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module qph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/qph_checker.sv =====
// Port-level checks for the quadratic-probe hash table, bound to the top level.
// Depends on qph_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module qph_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        s_axis_tvalid,
  input wire logic                        s_axis_tready,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tready,
  input wire logic [qph_pkg::OUT_BITS-1:0] m_axis_tdata
);

  localparam int CW = qph_pkg::CNT_BITS;

  // A stalled result keeps its valid.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result valid dropped while stalled");

  // One item at a time: the input closes right after a transfer.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input still open after a transfer");

  // Every result reports at least one probe.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[CW:1] != '0)
    else $error("result with zero probe count");

  // Reset empties the output register.
  assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind quadratic_probe_hash_table_top qph_checker u_qph_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
